/* rtl/core/cif_pkg.sv */
// ----------------------------------------------------------------------------
// cif_pkg: shared types and constants of the collision integral fit
// Beat formats, fixed-point widths, fit coefficients and the log table builder.
// ----------------------------------------------------------------------------
package cif_pkg;

  // Default parameter values
  localparam int TempFracBitsDef = 22;
  localparam int OutFracBitsDef  = 16;
  localparam int LogTableBitsDef = 8;

  // Field widths of the beats
  localparam int TempW = 32;
  localparam int GamW  = 20;
  localparam int ValW  = 25;

  // Internal Q16 value widths (signed), sized for the valid temperature range
  localparam int GW    = GamW + 1;
  localparam int LgW   = 22;
  localparam int L2W   = 24;
  localparam int L3W   = 27;
  localparam int L4W   = 30;
  localparam int L5W   = 32;
  localparam int GlgW  = 25;
  localparam int G2W   = 26;
  localparam int G2lgW = 29;
  localparam int Gl2W  = 28;
  localparam int Gl3W  = 31;
  localparam int Gl4W  = 33;

  // Term datapath widths
  localparam int SlotW  = 33;
  localparam int CoefW  = 36;
  localparam int HalfW  = 18;
  localparam int PartW  = HalfW + 1 + SlotW;
  localparam int TermW  = 48;
  localparam int SumW   = 52;
  localparam int NumSlots = 10;

  typedef logic [CoefW-1:0] coef_t;

  // Slot order: g, lg, g*lg, l2, g*l2, l3, g2|g*l3, g2*lg|l4, g*l4, l5
  localparam coef_t CubicCoef [NumSlots] = '{
    36'd51539607552, 36'd3809635992, 36'd27702539059, 36'd1181116006,
    36'd5325759447, 36'd704374637, 36'd16578573763, 36'd5153960755,
    36'd0, 36'd0
  };
  localparam coef_t HiCoef [NumSlots] = '{
    36'd147317378, 36'd3302829851, 36'd996432413, 36'd1314259993,
    36'd708669604, 36'd199715979, 36'd166644731, 36'd2637110,
    36'd12240657, 36'd1022202
  };
  // Bit k set: slot k is subtracted
  localparam logic [NumSlots-1:0] CubicNeg = 10'b00_0011_1111;
  localparam logic [NumSlots-1:0] HiNeg    = 10'b01_0011_0011;

  localparam coef_t CubicC0 = 36'd12756052869;
  localparam coef_t HiC0    = 36'd5239860101;

  typedef enum logic [1:0] {
    RS_OK   = 2'd0,
    RS_LOW  = 2'd1,
    RS_HIGH = 2'd2
  } range_status_e;

  typedef struct packed {
    logic [TempW-1:0] reduced_temp;
    logic [GamW-1:0]  dispersion_ratio;
  } cif_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] collision_value;
    logic [1:0]             range_status;
  } cif_out_t;

  // Log stage result
  typedef struct packed {
    logic signed [LgW-1:0] lg;
    logic [GamW-1:0]       g;
    range_status_e         status;
    logic                  cubic;
  } cif_lg_t;

  // Powers and gamma cross products, all Q16
  typedef struct packed {
    logic signed [LgW-1:0]   lg;
    logic [GamW-1:0]         g;
    logic signed [GlgW-1:0]  glg;
    logic signed [L2W-1:0]   l2;
    logic signed [G2W-1:0]   g2;
    logic signed [Gl2W-1:0]  gl2;
    logic signed [L3W-1:0]   l3;
    logic signed [G2lgW-1:0] g2lg;
    logic signed [Gl3W-1:0]  gl3;
    logic signed [L4W-1:0]   l4;
    logic signed [Gl4W-1:0]  gl4;
    logic signed [L5W-1:0]   l5;
    range_status_e           status;
    logic                    cubic;
  } cif_pow_t;

  // Q32 fit sum before rounding
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    range_status_e          status;
  } cif_sum_t;

  // Shift-subtract division, elaboration only
  function automatic logic [63:0] cif_udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rmd;
    quo = '0;
    rmd = '0;
    for (int b = 63; b >= 0; b--) begin
      rmd = {rmd[62:0], num[b]};
      if (rmd >= den) begin
        rmd = rmd - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1 + i/2^tab_bits) in Q16 via an atanh series in Q32, elaboration only
  function automatic logic [15:0] cif_log_entry(input logic [63:0] idx, input int tab_bits);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] res;
    z    = cif_udiv64(idx << 32, (64'd1 << (tab_bits + 1)) + idx);
    z2   = (z * z) >> 32;
    term = z;
    acc  = '0;
    for (int k = 1; k < 64; k += 2) begin
      acc  = acc + cif_udiv64(term, 64'(k));
      term = (term * z2) >> 32;
    end
    res = ((acc << 1) + 64'd32768) >> 16;
    return res[15:0];
  endfunction

endpackage

/* rtl/core/collision_integral_fit.sv */
// ----------------------------------------------------------------------------
// collision_integral_fit: fixed-point ion-neutral collision integral fit
// Input beat: reduced temperature and dispersion ratio. Output beat: the
// collision integral in Q8.16 (by default) and a range status.
//
// Usage:
//   Both channels are valid/stall. A beat moves on a rising edge with valid
//   high and stall low. Every input beat yields exactly one output beat, in
//   order. Temperatures below 0.01 or above 1000 return a zero value with
//   status low or high.
//   Throughput: one beat per cycle while the receiver does not stall.
//   From input beat to output valid, a beat passes four log stages
//   (range/leading-one, normalize, table, interpolate), four multiplier stages
//   for the powers of ln(T) (each power needs the previous one), five term
//   and sum stages, and the output register that rounds and saturates.
//   Reset clears only the stage valid bits; the data registers are not reset.
//   When the receiver stalls, the output beat holds; empty stages behind it
//   keep filling, and in_stall_o rises once all 14 stages hold beats.
// ----------------------------------------------------------------------------
module collision_integral_fit
  import cif_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = TempFracBitsDef,
  parameter int OUT_FRAC_BITS  = OutFracBitsDef,
  parameter int LOG_TABLE_BITS = LogTableBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  cif_in_t  in_data_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output cif_out_t out_data_o,
  input  logic     out_stall_i
);

  localparam int RW    = SumW + 1;
  localparam int Shift = 32 - OUT_FRAC_BITS;

  localparam logic signed [RW-1:0] HalfLsb = RW'(64'd1 << (Shift - 1));
  localparam logic signed [RW-1:0] ValMax  = RW'((64'd1 << (ValW - 1)) - 64'd1);
  localparam logic signed [RW-1:0] ValMin  = -ValMax - RW'(1);

  logic     lg_valid, lg_stall;
  cif_lg_t  lg_data;
  logic     pw_valid, pw_stall;
  cif_pow_t pw_data;
  logic     sm_valid, sm_stall;
  cif_sum_t sm_data;

  cif_log #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (lg_valid),
    .out_data_o  (lg_data),
    .out_stall_i (lg_stall)
  );

  cif_powers u_powers (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lg_valid),
    .in_data_i   (lg_data),
    .in_stall_o  (lg_stall),
    .out_valid_o (pw_valid),
    .out_data_o  (pw_data),
    .out_stall_i (pw_stall)
  );

  cif_terms u_terms (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pw_valid),
    .in_data_i   (pw_data),
    .in_stall_o  (pw_stall),
    .out_valid_o (sm_valid),
    .out_data_o  (sm_data),
    .out_stall_i (sm_stall)
  );

  // Output register: round half up, saturate, zero on range error
  logic     out_valid_q;
  cif_out_t out_q, out_d;
  logic     out_adv;

  assign out_adv  = ~out_valid_q | ~out_stall_i;
  assign sm_stall = ~out_adv;

  always_comb begin
    logic signed [RW-1:0] rsum;
    logic signed [RW-1:0] shifted;
    rsum    = RW'(sm_data.sum) + HalfLsb;
    shifted = rsum >>> Shift;
    if (sm_data.status != RS_OK) begin
      out_d.collision_value = '0;
    end else if (shifted > ValMax) begin
      out_d.collision_value = ValMax[ValW-1:0];
    end else if (shifted < ValMin) begin
      out_d.collision_value = ValMin[ValW-1:0];
    end else begin
      out_d.collision_value = shifted[ValW-1:0];
    end
    out_d.range_status = sm_data.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= sm_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/cif_log.sv */
// ----------------------------------------------------------------------------
// cif_log: range check and natural log of the reduced temperature
// Leading-one detect, normalize, mantissa table with linear interpolation.
// Four register stages.
// ----------------------------------------------------------------------------
module cif_log
  import cif_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = TempFracBitsDef,
  parameter int LOG_TABLE_BITS = LogTableBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  cif_in_t in_data_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  output cif_lg_t out_data_o,
  input  logic    out_stall_i
);

  localparam int Stages     = 4;
  localparam int TabEntries = 1 << LOG_TABLE_BITS;
  localparam int Low        = TempW - LOG_TABLE_BITS;

  localparam logic [63:0] One        = 64'd1 << TEMP_FRAC_BITS;
  localparam logic [63:0] LowLimit   = (One + 64'd99) / 64'd100;
  localparam logic [63:0] HighLimit  = 64'd1000 << TEMP_FRAC_BITS;
  localparam logic [63:0] CubicLimit = One / 64'd25;

  localparam logic [15:0]        Ln2  = cif_log_entry(64'(TabEntries), LOG_TABLE_BITS);
  localparam logic signed [16:0] Ln2S = $signed({1'b0, Ln2});
  localparam logic signed [6:0]  FracS = 7'(TEMP_FRAC_BITS);

  // Mantissa table, one entry past the end holds ln 2
  logic [15:0] log_tab [TabEntries+1];
  for (genvar gi = 0; gi <= TabEntries; gi++) begin : g_tab
    localparam logic [15:0] Entry = cif_log_entry(64'(gi), LOG_TABLE_BITS);
    assign log_tab[gi] = Entry;
  end

  // Stage handshake
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_d;
  logic [Stages:0]   adv;

  always_comb begin
    adv[Stages] = ~out_stall_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
    vld_d = {vld_q[Stages-2:0], in_valid_i};
  end

  assign in_stall_o  = ~adv[0];
  assign out_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // Stage 1: range compares and leading-one detect
  logic [TempW-1:0] x1_q;
  logic [GamW-1:0]  g1_q;
  range_status_e    st1_q, st1_d;
  logic             cub1_q, cub1_d;
  logic [4:0]       msb1_q, msb1_d;

  always_comb begin
    logic [63:0] xw;
    xw = 64'(in_data_i.reduced_temp);
    if (xw < LowLimit) begin
      st1_d = RS_LOW;
    end else if (xw > HighLimit) begin
      st1_d = RS_HIGH;
    end else begin
      st1_d = RS_OK;
    end
    cub1_d = (xw <= CubicLimit);
    msb1_d = '0;
    for (int b = 0; b < TempW; b++) begin
      if (in_data_i.reduced_temp[b]) begin
        msb1_d = 5'(b);
      end
    end
  end

  // Stage 2: drop the leading one and left-align the fraction
  logic [TempW-1:0] frac2_q, frac2_d;
  logic [4:0]       msb2_q;
  logic [GamW-1:0]  g2_q;
  range_status_e    st2_q;
  logic             cub2_q;

  always_comb begin
    logic [5:0]  sh;
    logic [63:0] wide;
    sh      = 6'd32 - {1'b0, msb1_q};
    wide    = {32'b0, x1_q} << sh;
    frac2_d = wide[TempW-1:0];
  end

  // Stage 3: table reads and exponent term
  logic [15:0]            e0_q, e0_d;
  logic [15:0]            dlt3_q, dlt3_d;
  logic [Low-1:0]         rem3_q;
  logic signed [LgW-1:0]  base3_q, base3_d;
  logic [GamW-1:0]        g3_q;
  range_status_e          st3_q;
  logic                   cub3_q;

  always_comb begin
    logic [LOG_TABLE_BITS:0] idx0;
    logic [LOG_TABLE_BITS:0] idx1;
    logic signed [6:0]       pe;
    logic signed [23:0]      bprod;
    idx0    = {1'b0, frac2_q[TempW-1 -: LOG_TABLE_BITS]};
    idx1    = idx0 + 1'b1;
    e0_d    = log_tab[idx0];
    dlt3_d  = log_tab[idx1] - log_tab[idx0];
    pe      = $signed({2'b00, msb2_q}) - FracS;
    bprod   = pe * Ln2S;
    base3_d = bprod[LgW-1:0];
  end

  // Stage 4: interpolate and assemble ln(T)
  cif_lg_t lg4_q, lg4_d;

  always_comb begin
    logic [16+Low-1:0] iprod;
    logic [16:0]       mant;
    iprod = dlt3_q * rem3_q;
    mant  = {1'b0, e0_q} + {1'b0, iprod[Low +: 16]};
    lg4_d.lg     = base3_q + $signed(LgW'(mant));
    lg4_d.g      = g3_q;
    lg4_d.status = st3_q;
    lg4_d.cubic  = cub3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      x1_q   <= in_data_i.reduced_temp;
      g1_q   <= in_data_i.dispersion_ratio;
      st1_q  <= st1_d;
      cub1_q <= cub1_d;
      msb1_q <= msb1_d;
    end
    if (adv[1]) begin
      frac2_q <= frac2_d;
      msb2_q  <= msb1_q;
      g2_q    <= g1_q;
      st2_q   <= st1_q;
      cub2_q  <= cub1_q;
    end
    if (adv[2]) begin
      e0_q    <= e0_d;
      dlt3_q  <= dlt3_d;
      rem3_q  <= frac2_q[Low-1:0];
      base3_q <= base3_d;
      g3_q    <= g2_q;
      st3_q   <= st2_q;
      cub3_q  <= cub2_q;
    end
    if (adv[3]) begin
      lg4_q <= lg4_d;
    end
  end

  assign out_data_o = lg4_q;

endmodule

/* rtl/core/cif_powers.sv */
// ----------------------------------------------------------------------------
// cif_powers: powers of ln(T) and their gamma cross products
// Four multiplier stages, each product floored back to Q16.
// ----------------------------------------------------------------------------
module cif_powers
  import cif_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  cif_lg_t  in_data_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output cif_pow_t out_data_o,
  input  logic     out_stall_i
);

  localparam int Stages = 4;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_d;
  logic [Stages:0]   adv;

  cif_pow_t pw_q [Stages];
  cif_pow_t pw_d [Stages];

  // Stage handshake
  always_comb begin
    adv[Stages] = ~out_stall_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
    vld_d = {vld_q[Stages-2:0], in_valid_i};
  end

  assign in_stall_o  = ~adv[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_data_o  = pw_q[Stages-1];

  // Products: l2, g*lg, g2 | l3, g*l2, g2*lg | l4, g*l3 | l5, g*l4
  always_comb begin
    logic signed [GW-1:0]        gs0;
    logic signed [GW-1:0]        gs1;
    logic signed [GW-1:0]        gs2;
    logic signed [GW-1:0]        gs3;
    logic signed [2*LgW-1:0]     p_ll;
    logic signed [GW+LgW-1:0]    p_gl;
    logic signed [2*GW-1:0]      p_gg;
    logic signed [L2W+LgW-1:0]   p_l3;
    logic signed [GW+L2W-1:0]    p_gl2;
    logic signed [G2W+LgW-1:0]   p_g2l;
    logic signed [L3W+LgW-1:0]   p_l4;
    logic signed [GW+L3W-1:0]    p_gl3;
    logic signed [L4W+LgW-1:0]   p_l5;
    logic signed [GW+L4W-1:0]    p_gl4;

    // stage 1
    gs0          = $signed({1'b0, in_data_i.g});
    p_ll         = in_data_i.lg * in_data_i.lg;
    p_gl         = gs0 * in_data_i.lg;
    p_gg         = gs0 * gs0;
    pw_d[0]        = '0;
    pw_d[0].lg     = in_data_i.lg;
    pw_d[0].g      = in_data_i.g;
    pw_d[0].status = in_data_i.status;
    pw_d[0].cubic  = in_data_i.cubic;
    pw_d[0].l2     = p_ll[16 +: L2W];
    pw_d[0].glg    = p_gl[16 +: GlgW];
    pw_d[0].g2     = p_gg[16 +: G2W];

    // stage 2
    gs1          = $signed({1'b0, pw_q[0].g});
    p_l3         = pw_q[0].l2 * pw_q[0].lg;
    p_gl2        = gs1 * pw_q[0].l2;
    p_g2l        = pw_q[0].g2 * pw_q[0].lg;
    pw_d[1]      = pw_q[0];
    pw_d[1].l3   = p_l3[16 +: L3W];
    pw_d[1].gl2  = p_gl2[16 +: Gl2W];
    pw_d[1].g2lg = p_g2l[16 +: G2lgW];

    // stage 3
    gs2          = $signed({1'b0, pw_q[1].g});
    p_l4         = pw_q[1].l3 * pw_q[1].lg;
    p_gl3        = gs2 * pw_q[1].l3;
    pw_d[2]      = pw_q[1];
    pw_d[2].l4   = p_l4[16 +: L4W];
    pw_d[2].gl3  = p_gl3[16 +: Gl3W];

    // stage 4
    gs3          = $signed({1'b0, pw_q[2].g});
    p_l5         = pw_q[2].l4 * pw_q[2].lg;
    p_gl4        = gs3 * pw_q[2].l4;
    pw_d[3]      = pw_q[2];
    pw_d[3].l5   = p_l5[16 +: L5W];
    pw_d[3].gl4  = p_gl4[16 +: Gl4W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (adv[k]) begin
        pw_q[k] <= pw_d[k];
      end
    end
  end

endmodule

/* rtl/core/cif_terms.sv */
// ----------------------------------------------------------------------------
// cif_terms: coefficient products and Q32 fit sum
// Ten term slots shared by both fit branches; split-coefficient multiplies,
// floor to Q32, sign, two partial sums, final sum with the constant term.
// ----------------------------------------------------------------------------
module cif_terms
  import cif_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  cif_pow_t in_data_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output cif_sum_t out_data_o,
  input  logic     out_stall_i
);

  localparam int Stages = 5;
  localparam int Half   = NumSlots / 2;
  localparam int CombW  = PartW + HalfW;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_d;
  logic [Stages:0]   adv;

  // Stage handshake
  always_comb begin
    adv[Stages] = ~out_stall_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
    vld_d = {vld_q[Stages-2:0], in_valid_i};
  end

  assign in_stall_o  = ~adv[0];
  assign out_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // Stage 1: slot select and partial products against coefficient halves
  logic signed [PartW-1:0] ph_q [NumSlots];
  logic signed [PartW-1:0] pl_q [NumSlots];
  logic signed [PartW-1:0] ph_d [NumSlots];
  logic signed [PartW-1:0] pl_d [NumSlots];
  range_status_e           st1_q;
  logic                    cub1_q;

  always_comb begin
    logic signed [SlotW-1:0] val [NumSlots];
    coef_t                   cf;
    val[0] = SlotW'($signed({1'b0, in_data_i.g}));
    val[1] = SlotW'(in_data_i.lg);
    val[2] = SlotW'(in_data_i.glg);
    val[3] = SlotW'(in_data_i.l2);
    val[4] = SlotW'(in_data_i.gl2);
    val[5] = SlotW'(in_data_i.l3);
    val[6] = in_data_i.cubic ? SlotW'(in_data_i.g2)   : SlotW'(in_data_i.gl3);
    val[7] = in_data_i.cubic ? SlotW'(in_data_i.g2lg) : SlotW'(in_data_i.l4);
    val[8] = SlotW'(in_data_i.gl4);
    val[9] = SlotW'(in_data_i.l5);
    for (int k = 0; k < NumSlots; k++) begin
      cf      = in_data_i.cubic ? CubicCoef[k] : HiCoef[k];
      ph_d[k] = $signed({1'b0, cf[CoefW-1:HalfW]}) * val[k];
      pl_d[k] = $signed({1'b0, cf[HalfW-1:0]}) * val[k];
    end
  end

  // Stage 2: recombine and floor to Q32
  logic signed [TermW-1:0] term_q [NumSlots];
  logic signed [TermW-1:0] term_d [NumSlots];
  range_status_e           st2_q;
  logic                    cub2_q;

  always_comb begin
    logic signed [CombW-1:0] comb;
    for (int k = 0; k < NumSlots; k++) begin
      comb      = (CombW'(ph_q[k]) <<< HalfW) + CombW'(pl_q[k]);
      term_d[k] = comb[16 +: TermW];
    end
  end

  // Stage 3: apply term signs of the active branch
  logic signed [TermW-1:0] tsg_q [NumSlots];
  logic signed [TermW-1:0] tsg_d [NumSlots];
  range_status_e           st3_q;
  logic                    cub3_q;

  always_comb begin
    logic [NumSlots-1:0] neg;
    neg = cub2_q ? CubicNeg : HiNeg;
    for (int k = 0; k < NumSlots; k++) begin
      tsg_d[k] = neg[k] ? -term_q[k] : term_q[k];
    end
  end

  // Stage 4: two partial sums
  logic signed [SumW-1:0] suma_q, suma_d;
  logic signed [SumW-1:0] sumb_q, sumb_d;
  range_status_e          st4_q;
  logic                   cub4_q;

  always_comb begin
    suma_d = '0;
    sumb_d = '0;
    for (int k = 0; k < Half; k++) begin
      suma_d = suma_d + SumW'(tsg_q[k]);
      sumb_d = sumb_d + SumW'(tsg_q[k+Half]);
    end
  end

  // Stage 5: add the constant term
  cif_sum_t sum_q, sum_d;

  always_comb begin
    coef_t c0;
    c0           = cub4_q ? CubicC0 : HiC0;
    sum_d.sum    = suma_q + sumb_q + $signed(SumW'(c0));
    sum_d.status = st4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      st1_q  <= in_data_i.status;
      cub1_q <= in_data_i.cubic;
    end
    if (adv[1]) begin
      term_q <= term_d;
      st2_q  <= st1_q;
      cub2_q <= cub1_q;
    end
    if (adv[2]) begin
      tsg_q  <= tsg_d;
      st3_q  <= st2_q;
      cub3_q <= cub2_q;
    end
    if (adv[3]) begin
      suma_q <= suma_d;
      sumb_q <= sumb_d;
      st4_q  <= st3_q;
      cub4_q <= cub3_q;
    end
    if (adv[4]) begin
      sum_q <= sum_d;
    end
  end

  assign out_data_o = sum_q;

endmodule
